/* src/shared_exclusive_lock_table_assert.svh */
// Assertion macros shared by the lock table modules.
// Needs a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_ASSERT_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_ASSERT_SVH

// The property holds in every cycle out of reset.
`define SLT_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lock table check failed");

// When the trigger holds, the result holds in the next cycle.
`define SLT_ASSERT_NEXT(label, trig, res) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (res)) \
		else $error("lock table sequence check failed");

`endif

/* src/slt_pkg.sv */
// Package for the shared/exclusive lock table: field widths, opcode and verdict codes,
// default sizes and the command and status words between controller and datapath.
// No dependencies.
package slt_pkg;

	localparam int TRANSACTIONS_DEF = 32;
	localparam int ITEMS_DEF = 256;

	localparam int OP_W = 2;
	localparam int TID_W = 5;
	localparam int IID_W = 8;
	localparam int VERDICT_W = 2;

	localparam logic [OP_W-1:0] OP_SHARED = 2'd0;
	localparam logic [OP_W-1:0] OP_EXCLUSIVE = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [VERDICT_W-1:0] V_GRANTED = 2'd0;
	localparam logic [VERDICT_W-1:0] V_DENIED = 2'd1;
	localparam logic [VERDICT_W-1:0] V_IGNORED = 2'd2;
	localparam logic [VERDICT_W-1:0] V_CLEARED = 2'd3;

	typedef struct packed {
		logic load;
		logic exec;
		logic sweep;
	} slt_cmd_t;

	typedef struct packed {
		logic op_clear;
		logic sweep_last;
	} slt_sts_t;

endpackage

/* src/slt_datapath.sv */
// Datapath of the lock table: request registers, the per-item lock memory,
// the blocked bitmap, the clearing counter and the verdict register.
// Depends on slt_pkg.
module slt_datapath #(
	parameter int TRANSACTIONS = slt_pkg::TRANSACTIONS_DEF,
	parameter int ITEMS = slt_pkg::ITEMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [slt_pkg::OP_W-1:0]       opcode,
	input  logic [slt_pkg::TID_W-1:0]      transaction_id,
	input  logic [slt_pkg::IID_W-1:0]      item_id,
	input  slt_pkg::slt_cmd_t              cmd,
	output slt_pkg::slt_sts_t              sts,
	output logic [slt_pkg::VERDICT_W-1:0]  verdict
);
	import slt_pkg::*;

	localparam int TW = $clog2(TRANSACTIONS);
	localparam int IW = $clog2(ITEMS);
	localparam int TID_N = 2 ** TID_W;
	localparam int IID_N = 2 ** IID_W;

	typedef struct packed {
		logic                    valid;
		logic [TW-1:0]           owner;
		logic [TRANSACTIONS-1:0] shared;
	} entry_t;

	logic [TW-1:0]           tid_map [TID_N];
	logic [IW-1:0]           iid_map [IID_N];
	entry_t                  mem_q [ITEMS];
	entry_t                  rd_q;
	entry_t                  entry_d;
	entry_t                  wd;
	logic [OP_W-1:0]         op_q;
	logic [TW-1:0]           tid_q;
	logic [IW-1:0]           iid_q;
	logic [TRANSACTIONS-1:0] blocked_q;
	logic [IW-1:0]           cnt_q;
	logic [VERDICT_W-1:0]    verdict_q;
	logic [VERDICT_W-1:0]    verdict_d;
	logic [TRANSACTIONS-1:0] me;
	logic                    ignored;
	logic                    owned;
	logic                    mine;
	logic                    others;
	logic                    deny;
	logic                    we;
	logic [IW-1:0]           wa;

	// Index reduction tables, built from constants at elaboration.
	for (genvar g = 0; g < TID_N; g++) begin : g_tid_map
		assign tid_map[g] = TW'(g % TRANSACTIONS);
	end
	for (genvar g = 0; g < IID_N; g++) begin : g_iid_map
		assign iid_map[g] = IW'(g % ITEMS);
	end

	assign me = {{(TRANSACTIONS-1){1'b0}}, 1'b1} << tid_q;
	assign ignored = !(op_q == OP_SHARED || op_q == OP_EXCLUSIVE) || blocked_q[tid_q];
	assign owned = rd_q.valid;
	assign mine = owned && (rd_q.owner == tid_q);
	assign others = (rd_q.shared & ~me) != '0;

	always_comb begin
		entry_d = rd_q;
		deny = 1'b0;
		verdict_d = V_GRANTED;
		if (op_q == OP_CLEAR) begin
			verdict_d = V_CLEARED;
		end else if (ignored) begin
			verdict_d = V_IGNORED;
		end else if (op_q == OP_SHARED) begin
			if (!owned) begin
				entry_d.shared = rd_q.shared | me;
			end else if (!mine) begin
				deny = 1'b1;
			end
		end else begin
			if ((owned && !mine) || others) begin
				deny = 1'b1;
			end else if (!owned) begin
				entry_d.valid = 1'b1;
				entry_d.owner = tid_q;
			end
		end
		if (deny) begin
			verdict_d = V_DENIED;
		end
	end

	assign we = cmd.sweep || (cmd.exec && op_q != OP_CLEAR);
	assign wa = cmd.sweep ? cnt_q : iid_q;
	assign wd = cmd.sweep ? '0 : entry_d;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (cmd.load) begin
			rd_q <= mem_q[iid_map[item_id]];
			op_q <= opcode;
			tid_q <= tid_map[transaction_id];
			iid_q <= iid_map[item_id];
		end
		if (cmd.exec) begin
			verdict_q <= verdict_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.exec) begin
				cnt_q <= '0;
				if (op_q == OP_CLEAR) begin
					blocked_q <= '0;
				end else if (deny) begin
					blocked_q <= blocked_q | me;
				end
			end else if (cmd.sweep) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	assign sts.op_clear = (op_q == OP_CLEAR);
	assign sts.sweep_last = (cnt_q == IW'(ITEMS - 1));
	assign verdict = verdict_q;

endmodule

/* src/slt_ctrl.sv */
// Controller of the lock table: request and response handshakes and the
// sequencing of load, evaluate and table clearing. Depends on slt_pkg and the assertion header.
`include "shared_exclusive_lock_table_assert.svh"
module slt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output slt_pkg::slt_cmd_t cmd,
	input  slt_pkg::slt_sts_t sts
);
	import slt_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d = sts.op_clear ? ST_CLEAR : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`SLT_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.load, cmd.exec, cmd.sweep}))
	`SLT_ASSERT_NEXT(a_load_to_exec, cmd.load, state_q == ST_EXEC && !req_ready)
	`SLT_ASSERT_NEXT(a_exec_gives_word, cmd.exec, rsp_valid)
	`SLT_ASSERT_NEXT(a_sweep_ends, cmd.sweep && sts.sweep_last, state_q == ST_IDLE)
	`SLT_ASSERT_ALWAYS(a_exec_only_free, !cmd.exec || out_free)

endmodule

/* src/shared_exclusive_lock_table.sv */
// Top level of the shared/exclusive lock table: controller plus datapath.
// Depends on slt_pkg, slt_ctrl and slt_datapath.
//
// Channel   Signals                                    Direction
// request   req_valid, req_ready, opcode,              in
//           transaction_id, item_id
// response  rsp_valid, rsp_ready, verdict               out
//
// For a shared or exclusive request, the accept edge reads the item's entry from
// the lock memory, and the evaluate step writes it back and loads the verdict.
// A clear-all then sweeps all ITEMS entries of the lock memory to zero, one entry
// per cycle; reset starts the same sweep.
// The evaluate step waits while the previous verdict word is still untaken.
module shared_exclusive_lock_table #(
	parameter int TRANSACTIONS = slt_pkg::TRANSACTIONS_DEF,
	parameter int ITEMS = slt_pkg::ITEMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [slt_pkg::OP_W-1:0]       opcode,
	input  logic [slt_pkg::TID_W-1:0]      transaction_id,
	input  logic [slt_pkg::IID_W-1:0]      item_id,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [slt_pkg::VERDICT_W-1:0]  verdict
);
	import slt_pkg::*;

	slt_cmd_t cmd;
	slt_sts_t sts;

	slt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	slt_datapath #(
		.TRANSACTIONS (TRANSACTIONS),
		.ITEMS        (ITEMS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.opcode         (opcode),
		.transaction_id (transaction_id),
		.item_id        (item_id),
		.cmd            (cmd),
		.sts            (sts),
		.verdict        (verdict)
	);

endmodule
